[rtl/chbd_pkg.sv]
// Package: beat types, phase encoding and character helpers for the chunked body decoder.
`default_nettype none
package chbd_pkg;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       first_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
    logic [1:0] end_status;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_LINE   = 3'd0,
    PH_DATA   = 3'd1,
    PH_OPT_CR = 3'd2,
    PH_OPT_LF = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_OK  = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/chbd_parser.sv]
// Chunk framing parser: per-beat state update and result formation.
`default_nettype none
module chbd_parser #(
  parameter int SIZE_BITS = 32,
  parameter int LINE_KEEP = 31
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire chbd_pkg::in_item_t item,
  output logic                    res_valid,
  output chbd_pkg::out_item_t     res_item
);

  localparam int LCW = $clog2(LINE_KEEP + 1);

  typedef struct packed {
    logic [SIZE_BITS-1:0] acc;
    logic                 ov;
    logic [LCW-1:0]       chars;
    logic                 seen;
    logic                 stopped;
    logic                 prev_cr;
  } line_t;

  function automatic line_t line_char(line_t s, logic [7:0] c);
    line_t      r;
    logic [4:0] hv;
    r  = s;
    hv = chbd_pkg::hex_decode(c);
    if (s.chars < LCW'(LINE_KEEP)) begin
      if (s.stopped || !hv[4]) begin
        r.stopped = 1'b1;
      end else begin
        if (s.acc[SIZE_BITS-1 -: 4] != 4'd0) r.ov = 1'b1;
        r.acc  = {s.acc[SIZE_BITS-5:0], hv[3:0]};
        r.seen = 1'b1;
      end
      r.chars = s.chars + 1'b1;
    end
    return r;
  endfunction

  chbd_pkg::phase_t     phase_r, phase_nxt;
  line_t                line_r, line_nxt;
  logic [SIZE_BITS-1:0] bytes_left_r, bytes_left_nxt;

  chbd_pkg::phase_t     ph;
  line_t                ln, lw;
  logic [SIZE_BITS-1:0] bl;
  logic [7:0]           c;
  logic                 active, pay_valid, line_path;
  logic [1:0]           status;

  assign c  = item.body_byte;
  assign ph = item.first_byte ? chbd_pkg::PH_LINE : phase_r;
  assign ln = item.first_byte ? line_t'('0) : line_r;
  assign bl = item.first_byte ? '0 : bytes_left_r;

  // next state
  always_comb begin
    phase_nxt      = ph;
    line_nxt       = ln;
    bytes_left_nxt = bl;
    active         = 1'b1;
    pay_valid      = 1'b0;
    line_path      = 1'b0;
    status         = chbd_pkg::ST_RUN;
    lw             = ln;
    unique case (ph)
      chbd_pkg::PH_DONE: begin
        active = 1'b0;
      end
      chbd_pkg::PH_DATA: begin
        pay_valid      = 1'b1;
        bytes_left_nxt = bl - 1'b1;
        if (bl == SIZE_BITS'(1)) phase_nxt = chbd_pkg::PH_OPT_CR;
      end
      chbd_pkg::PH_OPT_CR: begin
        if (c == chbd_pkg::CH_CR) begin
          phase_nxt = chbd_pkg::PH_OPT_LF;
        end else if (c == chbd_pkg::CH_LF) begin
          phase_nxt = chbd_pkg::PH_LINE;
          line_nxt  = '0;
        end else begin
          line_path = 1'b1;
        end
      end
      chbd_pkg::PH_OPT_LF: begin
        if (c == chbd_pkg::CH_LF) begin
          phase_nxt = chbd_pkg::PH_LINE;
          line_nxt  = '0;
        end else begin
          line_path = 1'b1;
        end
      end
      chbd_pkg::PH_LINE: begin
        line_path = 1'b1;
      end
      default: begin
        active = 1'b0;
      end
    endcase

    if (line_path) begin
      phase_nxt = chbd_pkg::PH_LINE;
      lw        = (ph != chbd_pkg::PH_LINE) ? line_t'('0) : ln;
      if (c == chbd_pkg::CH_LF) begin
        lw.prev_cr = 1'b0;
        if (lw.chars == '0 || !lw.seen || lw.ov) begin
          status = chbd_pkg::ST_ERR;
        end else if (lw.acc == '0) begin
          status = chbd_pkg::ST_OK;
        end else begin
          bytes_left_nxt = lw.acc;
          phase_nxt      = chbd_pkg::PH_DATA;
          lw             = '0;
        end
      end else begin
        if (lw.prev_cr) lw = line_char(lw, chbd_pkg::CH_CR);
        lw.prev_cr = (c == chbd_pkg::CH_CR);
        if (!lw.prev_cr) lw = line_char(lw, c);
      end
      line_nxt = lw;
    end

    if (active && status == chbd_pkg::ST_RUN && item.final_byte) status = chbd_pkg::ST_ERR;
    if (status != chbd_pkg::ST_RUN) phase_nxt = chbd_pkg::PH_DONE;
  end

  // result
  always_comb begin
    res_valid            = accept && (pay_valid || status != chbd_pkg::ST_RUN);
    res_item.data_byte   = pay_valid ? c : 8'd0;
    res_item.byte_valid  = pay_valid;
    res_item.message_end = (status != chbd_pkg::ST_RUN);
    res_item.end_status  = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= chbd_pkg::PH_LINE;
      line_r       <= '0;
      bytes_left_r <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      line_r       <= line_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/chbd_outbuf.sv]
// Two-entry result buffer that decouples parser acceptance from output stalls.
`default_nettype none
module chbd_outbuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_valid,
  input  wire chbd_pkg::out_item_t wr_item,
  output logic                     space,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output chbd_pkg::out_item_t      out_item
);

  chbd_pkg::out_item_t slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                push, pop;

  assign space     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = slot0_r;
  assign push      = wr_valid && space;
  assign pop       = out_valid && out_ready;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) slot0_nxt = wr_item;
        else slot1_nxt = wr_item;
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        cnt_nxt   = cnt_r - 2'd1;
      end
      2'b11: begin
        slot0_nxt = wr_item;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

endmodule
`default_nettype wire

[rtl/http_chunked_body_decoder_core.sv]
// Top level: HTTP chunked body decoder, parser plus result buffer.
// Each result is registered in the result buffer and offered on out_ behind older results.
// Throughput: one body byte per cycle while in_ready is high; the per-byte state update
// in the parser is combinational, and the two-entry result buffer keeps in_ready high
// while it holds fewer than two results, so a single stalled result does not block input.
// Reset (synchronous, rst_n low): parser returns to the size line phase, buffer empties.
`default_nettype none
module http_chunked_body_decoder_core #(
  parameter int SIZE_BITS = 32,
  parameter int LINE_KEEP = 31
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire chbd_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output chbd_pkg::out_item_t      out_item
);

  logic                accept, res_valid;
  chbd_pkg::out_item_t res_item;

  assign accept = in_valid && in_ready;

  chbd_parser #(
    .SIZE_BITS(SIZE_BITS),
    .LINE_KEEP(LINE_KEEP)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .res_valid(res_valid),
    .res_item (res_item)
  );

  chbd_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (res_valid),
    .wr_item  (res_item),
    .space    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule
`default_nettype wire
